FILE: rtl/core/frsp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and text-matching functions for the file response parser.
// Used by the front, back, top level and checker; depends on nothing else.
package frsp_pkg;

  localparam logic [2:0] ST_PENDING   = 3'd0;
  localparam logic [2:0] ST_OK        = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_ERROR     = 3'd3;
  localparam logic [2:0] ST_INVALID   = 3'd4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [3:0] SCHEME_LEN = 4'd7;
  localparam logic [3:0] INDEX_MAX  = 4'd15;
  localparam logic [3:0] OK_LEN     = 4'd2;

  typedef enum logic [7:0] {
    PH_PRE_SCHEME = 8'b0000_0001,
    PH_SCHEME     = 8'b0000_0010,
    PH_PRE_STATUS = 8'b0000_0100,
    PH_STATUS     = 8'b0000_1000,
    PH_PRE_SIZE   = 8'b0001_0000,
    PH_SIZE       = 8'b0010_0000,
    PH_TERM       = 8'b0100_0000,
    PH_CONTENT    = 8'b1000_0000
  } phase_t;

  // One received beat after classification by the front end.
  typedef struct packed {
    logic       mode;
    logic [7:0] data;
    logic       is_space;
    logic       is_cr;
    logic       is_lf;
    logic       is_digit;
    logic [3:0] digit;
  } item_t;

  function automatic logic [7:0] scheme_char(input logic [3:0] i);
    logic [55:0] t;
    t = "GETFILE";
    if (i >= SCHEME_LEN) begin
      return 8'h00;
    end
    return t[8 * (6 - int'(i)) +: 8];
  endfunction

  function automatic logic [3:0] status_len(input logic [1:0] k);
    case (k)
      2'd0: return 4'd2;
      2'd1: return 4'd14;
      2'd2: return 4'd5;
      default: return 4'd7;
    endcase
  endfunction

  function automatic logic [7:0] status_char(input logic [1:0] k, input logic [3:0] i);
    logic [111:0] t;
    case (k)
      2'd0: t = {"OK", 96'h0};
      2'd1: t = {"FILE_", "NOT_FOUND"};
      2'd2: t = {"ERROR", 72'h0};
      default: t = {"INVALID", 56'h0};
    endcase
    if (i > 4'd13) begin
      return 8'h00;
    end
    return t[8 * (13 - int'(i)) +: 8];
  endfunction

  function automatic logic [2:0] status_code(input logic [1:0] k);
    case (k)
      2'd0: return ST_OK;
      2'd1: return ST_NOT_FOUND;
      2'd2: return ST_ERROR;
      default: return ST_INVALID;
    endcase
  endfunction

endpackage

FILE: rtl/core/file_response_stream_parser_top.sv
`timescale 1ns / 1ps
// Top level of the file response stream parser: front end queue plus back end parser.
// Depends on frsp_pkg, frsp_front and frsp_back.
//
// Usage: each input beat carries either one received byte (mode 0, rx_byte) or a
// connection-closed event (mode 1). Every input beat produces exactly one output beat
// that reports whether the byte was passed on as file content, plus the running report:
// done flag, status code, failure flag, parsed file size and content bytes so far.
// Both channels use valid/ready; a beat moves when valid and ready are high together.
// Throughput is one beat per cycle while the receiver does not stall the output; the back
// end parser updates its state as each beat is popped. An accepted beat is registered in
// the two-entry front queue and then in the back end output register before output valid.
// When the receiver stalls, the output register holds its beat and the front queue
// keeps accepting until both of its entries are full; then in_ready drops.
// Reset (rst, synchronous, active high) empties the queue, clears the output valid flag
// and returns the parser to the state before the scheme token with nothing received.
// HEADER_MAX sets the longest header accepted, in bytes (32 to 1024).
module file_response_stream_parser_top #(
  parameter int HEADER_MAX = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        content_valid,
  output logic [7:0]  content_byte,
  output logic        done_res,
  output logic [2:0]  status,
  output logic        transfer_failed,
  output logic [31:0] parsed_size,
  output logic [31:0] content_total
);

  // Classified bytes cross from the front end to the back end through this queue port.
  logic            q_valid;
  logic            q_pop;
  frsp_pkg::item_t q_item;

  frsp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .rx_byte  (rx_byte),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // The back end pops a beat whenever its output register is free or being drained.
  frsp_back #(
    .HEADER_MAX (HEADER_MAX)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .content_valid   (content_valid),
    .content_byte    (content_byte),
    .done_res        (done_res),
    .status          (status),
    .transfer_failed (transfer_failed),
    .parsed_size     (parsed_size),
    .content_total   (content_total)
  );

endmodule

FILE: rtl/core/frsp_front.sv
`timescale 1ns / 1ps
// Front end: accepts input beats, classifies each byte and holds it in a two-entry queue.
// Depends on frsp_pkg.
module frsp_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           mode,
  input  logic [7:0]     rx_byte,
  output logic           q_valid,
  output frsp_pkg::item_t q_item,
  input  logic           q_pop
);

  frsp_pkg::item_t slots [2];
  frsp_pkg::item_t cls;
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            push;

  always_comb begin
    cls.mode     = mode;
    cls.data     = rx_byte;
    cls.is_space = (rx_byte == frsp_pkg::CH_SPACE);
    cls.is_cr    = (rx_byte == frsp_pkg::CH_CR);
    cls.is_lf    = (rx_byte == frsp_pkg::CH_LF);
    cls.is_digit = (rx_byte >= frsp_pkg::CH_ZERO) && (rx_byte <= frsp_pkg::CH_NINE);
    cls.digit    = rx_byte[3:0];
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

FILE: rtl/core/frsp_back.sv
`timescale 1ns / 1ps
// Back end: header parser state machine, content counter and the output register.
// Depends on frsp_pkg; takes classified beats from frsp_front.
module frsp_back #(
  parameter int HEADER_MAX = 512
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  frsp_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            content_valid,
  output logic [7:0]      content_byte,
  output logic            done_res,
  output logic [2:0]      status,
  output logic            transfer_failed,
  output logic [31:0]     parsed_size,
  output logic [31:0]     content_total
);

  localparam int HL_W = $clog2(HEADER_MAX + 1);

  frsp_pkg::phase_t phase, phase_next;
  logic [3:0]       token_index, token_index_next;
  logic [3:0]       status_candidates, status_candidates_next;
  logic [1:0]       terminator_match, terminator_match_next;
  logic [31:0]      size_accumulator, size_accumulator_next;
  logic [31:0]      content_count, content_count_next;
  logic [HL_W-1:0]  header_length, header_length_next;
  logic [2:0]       result_code, result_code_next;
  logic             finished, finished_next;

  logic             cv;
  logic             pre;
  logic [3:0]       eff_ti;
  logic [3:0]       eff_cand;
  logic [3:0]       keep;
  logic             cr_hit;
  logic [1:0]       cr_k;
  logic             hc_hit;
  logic [1:0]       hc_k;
  logic [35:0]      size_mac;
  logic             failed;
  logic [7:0]       c;

  assign q_pop = q_valid && (!out_valid || out_ready);
  assign c     = q_item.data;

  always_comb begin
    phase_next             = phase;
    token_index_next       = token_index;
    status_candidates_next = status_candidates;
    terminator_match_next  = terminator_match;
    size_accumulator_next  = size_accumulator;
    content_count_next     = content_count;
    header_length_next     = header_length;
    result_code_next       = result_code;
    finished_next          = finished;
    cv                     = 1'b0;

    // The "pre" phases hand a non-space byte to the token phase that follows them.
    pre = (phase == frsp_pkg::PH_PRE_SCHEME) || (phase == frsp_pkg::PH_PRE_STATUS)
       || (phase == frsp_pkg::PH_PRE_SIZE);
    eff_ti   = pre ? 4'd0 : token_index;
    eff_cand = (phase == frsp_pkg::PH_PRE_STATUS) ? 4'hF : status_candidates;

    keep   = 4'd0;
    cr_hit = 1'b0;
    cr_k   = 2'd1;
    hc_hit = 1'b0;
    hc_k   = 2'd0;
    for (int k = 0; k < 4; k++) begin
      keep[k] = eff_cand[k] && (eff_ti < frsp_pkg::status_len(2'(k)))
             && (frsp_pkg::status_char(2'(k), eff_ti) == c);
    end
    for (int k = 3; k >= 1; k--) begin
      if (eff_cand[k] && frsp_pkg::status_len(2'(k)) == eff_ti) begin
        cr_hit = 1'b1;
        cr_k   = 2'(k);
      end
    end
    for (int k = 3; k >= 0; k--) begin
      if (status_candidates[k]) begin
        hc_hit = 1'b1;
        hc_k   = 2'(k);
      end
    end
    size_mac = {1'b0, size_accumulator, 3'b000} + {3'b000, size_accumulator, 1'b0}
             + {32'd0, q_item.digit};

    if (q_pop && !finished) begin
      if (q_item.mode) begin
        if (phase != frsp_pkg::PH_CONTENT) begin
          result_code_next = frsp_pkg::ST_INVALID;
        end
        finished_next = 1'b1;
      end else if (phase == frsp_pkg::PH_CONTENT) begin
        if (content_count < size_accumulator) begin
          cv                 = 1'b1;
          content_count_next = content_count + 32'd1;
        end
        if (content_count_next >= size_accumulator) begin
          finished_next = 1'b1;
        end
      end else if (header_length >= HL_W'(HEADER_MAX)) begin
        result_code_next = frsp_pkg::ST_INVALID;
        finished_next    = 1'b1;
      end else begin
        header_length_next = header_length + HL_W'(1);
        case (phase)
          frsp_pkg::PH_PRE_SCHEME, frsp_pkg::PH_SCHEME: begin
            if (!(pre && q_item.is_space)) begin
              phase_next       = frsp_pkg::PH_SCHEME;
              token_index_next = eff_ti;
              if (eff_ti < frsp_pkg::SCHEME_LEN && c == frsp_pkg::scheme_char(eff_ti)) begin
                token_index_next = eff_ti + 4'd1;
              end else if (eff_ti == frsp_pkg::SCHEME_LEN && q_item.is_space) begin
                phase_next = frsp_pkg::PH_PRE_STATUS;
              end else begin
                result_code_next = frsp_pkg::ST_INVALID;
                finished_next    = 1'b1;
              end
            end
          end
          frsp_pkg::PH_PRE_STATUS, frsp_pkg::PH_STATUS: begin
            if (!(pre && q_item.is_space)) begin
              phase_next             = frsp_pkg::PH_STATUS;
              token_index_next       = eff_ti;
              status_candidates_next = eff_cand;
              if (q_item.is_space) begin
                if (eff_ti == frsp_pkg::OK_LEN && eff_cand[0]) begin
                  phase_next            = frsp_pkg::PH_PRE_SIZE;
                  size_accumulator_next = 32'd0;
                  token_index_next      = 4'd0;
                end else begin
                  result_code_next = frsp_pkg::ST_INVALID;
                  finished_next    = 1'b1;
                end
              end else if (q_item.is_cr) begin
                if (cr_hit) begin
                  status_candidates_next = 4'(1) << cr_k;
                  phase_next             = frsp_pkg::PH_TERM;
                  terminator_match_next  = 2'd1;
                end else begin
                  result_code_next = frsp_pkg::ST_INVALID;
                  finished_next    = 1'b1;
                end
              end else begin
                status_candidates_next = keep;
                if (keep == 4'd0) begin
                  result_code_next = frsp_pkg::ST_INVALID;
                  finished_next    = 1'b1;
                end else if (eff_ti < frsp_pkg::INDEX_MAX) begin
                  token_index_next = eff_ti + 4'd1;
                end
              end
            end
          end
          frsp_pkg::PH_PRE_SIZE, frsp_pkg::PH_SIZE: begin
            if (!(pre && q_item.is_space)) begin
              phase_next       = frsp_pkg::PH_SIZE;
              token_index_next = eff_ti;
              if (q_item.is_digit) begin
                if (size_mac[35:32] != 4'd0) begin
                  result_code_next = frsp_pkg::ST_INVALID;
                  finished_next    = 1'b1;
                end else begin
                  size_accumulator_next = size_mac[31:0];
                  if (eff_ti < frsp_pkg::INDEX_MAX) begin
                    token_index_next = eff_ti + 4'd1;
                  end
                end
              end else if (q_item.is_cr && eff_ti != 4'd0) begin
                status_candidates_next = 4'd1;
                phase_next             = frsp_pkg::PH_TERM;
                terminator_match_next  = 2'd1;
              end else begin
                result_code_next = frsp_pkg::ST_INVALID;
                finished_next    = 1'b1;
              end
            end
          end
          frsp_pkg::PH_TERM: begin
            // Odd positions of the terminator expect LF, even ones CR.
            if ((terminator_match[0] && q_item.is_lf) || (!terminator_match[0] && q_item.is_cr))
            begin
              terminator_match_next = terminator_match + 2'd1;
              if (terminator_match == 2'd3) begin
                if (!hc_hit) begin
                  result_code_next = frsp_pkg::ST_INVALID;
                  finished_next    = 1'b1;
                end else begin
                  result_code_next = frsp_pkg::status_code(hc_k);
                  if (hc_k == 2'd0 && size_accumulator != 32'd0) begin
                    phase_next = frsp_pkg::PH_CONTENT;
                  end else begin
                    finished_next = 1'b1;
                  end
                end
              end
            end else begin
              result_code_next = frsp_pkg::ST_INVALID;
              finished_next    = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end

    failed = finished_next && ((result_code_next == frsp_pkg::ST_INVALID)
          || (result_code_next == frsp_pkg::ST_OK
              && content_count_next != size_accumulator_next));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= frsp_pkg::PH_PRE_SCHEME;
      token_index       <= 4'd0;
      status_candidates <= 4'hF;
      terminator_match  <= 2'd0;
      size_accumulator  <= 32'd0;
      content_count     <= 32'd0;
      header_length     <= '0;
      result_code       <= frsp_pkg::ST_PENDING;
      finished          <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      phase             <= phase_next;
      token_index       <= token_index_next;
      status_candidates <= status_candidates_next;
      terminator_match  <= terminator_match_next;
      size_accumulator  <= size_accumulator_next;
      content_count     <= content_count_next;
      header_length     <= header_length_next;
      result_code       <= result_code_next;
      finished          <= finished_next;
      if (q_pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      content_valid   <= cv;
      content_byte    <= cv ? c : 8'h00;
      done_res        <= finished_next;
      status          <= result_code_next;
      transfer_failed <= failed;
      parsed_size     <= (result_code_next == frsp_pkg::ST_OK) ? size_accumulator_next : 32'd0;
      content_total   <= content_count_next;
    end
  end

endmodule

FILE: rtl/core/frsp_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the file response stream parser, bound to the top level.
// Depends on frsp_pkg.
module frsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        content_valid,
  input logic [7:0]  content_byte,
  input logic        done_res,
  input logic [2:0]  status,
  input logic        transfer_failed,
  input logic [31:0] parsed_size,
  input logic [31:0] content_total
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(content_byte) && $stable(content_total))
    else $error("output beat changed while stalled");

  a_content_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && content_valid |-> status == frsp_pkg::ST_OK && content_total != 32'd0
      && content_total <= parsed_size)
    else $error("content passed without an OK header");

  a_fail_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && transfer_failed |-> done_res)
    else $error("failure reported before the transfer finished");

  a_size_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != frsp_pkg::ST_OK |-> parsed_size == 32'd0 && !content_valid)
    else $error("size reported without an OK status");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind file_response_stream_parser_top frsp_checker u_frsp_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .content_valid   (content_valid),
  .content_byte    (content_byte),
  .done_res        (done_res),
  .status          (status),
  .transfer_failed (transfer_failed),
  .parsed_size     (parsed_size),
  .content_total   (content_total)
);
